// ===== rtl/ilist_pkg.sv =====
// Shared types, codes and sizes for the indexed insert/remove list.
// No dependencies; imported by every module of the block.
package ilist_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int AW         = $clog2(DEPTH);      // slot address
  localparam int CW         = $clog2(DEPTH + 1);  // entry count
  localparam int CAP_W      = 7;                  // capacity register
  localparam int POS_W      = 10;                 // wide position compares

  localparam logic [1:0] OP_READ   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;  // unused: no effect, status ok

  localparam logic [1:0] MODE_INDEX = 2'd0;
  localparam logic [1:0] MODE_FIRST = 2'd1;
  localparam logic [1:0] MODE_LAST  = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;  // unused: bad index

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  localparam logic [2:0] ADDR_CAPACITY = 3'd0;  // capacity_limit register

  typedef struct packed {
    logic                  we;
    logic [AW-1:0]         waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic                  re;
    logic [AW-1:0]         raddr;
  } mem_req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [31:0]      read_value;
    logic [CAP_W-1:0] entry_total;
    logic             is_empty;
    logic             is_full;
  } result_t;

  // capacity saturates at the slot count
  function automatic logic [CW-1:0] eff_cap(input logic [CAP_W-1:0] cap);
    if (POS_W'(cap) > POS_W'(DEPTH)) return CW'(DEPTH);
    else return CW'(cap);
  endfunction

endpackage

// ===== rtl/ilist_mem.sv =====
// Slot storage: one write port and one read port, registered read data.
// Depends on ilist_pkg.
module ilist_mem
  import ilist_pkg::*;
(
  input  logic                  clk,
  input  mem_req_t              req,
  output logic [DATA_WIDTH-1:0] rdata
);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

// ===== rtl/ilist_ctrl.sv =====
// Request sequencer: checks a request, then moves slots one per read/write pair.
// Depends on ilist_pkg; drives ilist_mem through a mem_req_t.
module ilist_ctrl
  import ilist_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CAP_W-1:0]      capacity_limit,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  logic [1:0]            operation,
  input  logic [1:0]            position_mode,
  input  logic [7:0]            index,
  input  logic [31:0]           element_value,
  output mem_req_t              mem_req,
  input  logic [DATA_WIDTH-1:0] mem_rdata,
  output logic                  res_valid,
  input  logic                  res_take,
  output result_t               res
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_WR   = 5'b00100,
    S_PUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                state, state_next;
  logic [CW-1:0]         count, count_next;
  logic [AW-1:0]         ptr, ptr_next;
  logic [AW-1:0]         pos, pos_next;
  logic [1:0]            op, op_next;
  logic [1:0]            status, status_next;
  logic [DATA_WIDTH-1:0] word, word_next;

  logic [CW-1:0]    cap;
  logic [POS_W-1:0] cand;
  logic [POS_W-1:0] cnt_w;
  logic [POS_W-1:0] ptr_w;
  logic [POS_W-1:0] pos_w;

  assign cap   = eff_cap(capacity_limit);
  assign cnt_w = POS_W'(count);
  assign ptr_w = POS_W'(ptr);
  assign pos_w = POS_W'(pos);

  assign req_ready = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  // candidate position from the request's mode
  always_comb begin
    case (position_mode)
      MODE_INDEX: cand = POS_W'(index);
      MODE_FIRST: cand = '0;
      MODE_LAST:  cand = (operation == OP_INSERT) ? cnt_w : cnt_w - POS_W'(1);
      default:    cand = '0;
    endcase
  end

  always_comb begin
    state_next  = state;
    count_next  = count;
    ptr_next    = ptr;
    pos_next    = pos;
    op_next     = op;
    status_next = status;
    word_next   = word;
    mem_req     = '0;

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          op_next     = operation;
          word_next   = element_value[DATA_WIDTH-1:0];
          pos_next    = cand[AW-1:0];
          status_next = ST_OK;
          state_next  = S_DONE;
          if (operation == OP_INSERT) begin
            if (count >= cap) begin
              status_next = ST_FULL;
            end else if (position_mode == MODE_NONE || cand > cnt_w) begin
              status_next = ST_BADIDX;
            end else begin
              ptr_next   = count[AW-1:0];
              state_next = (cnt_w > cand) ? S_RD : S_PUT;
            end
          end else if (operation == OP_READ || operation == OP_REMOVE) begin
            if (count == '0) begin
              status_next = ST_EMPTY;
            end else if (position_mode == MODE_NONE || cand >= cnt_w) begin
              status_next = ST_BADIDX;
            end else if (operation == OP_READ) begin
              ptr_next   = cand[AW-1:0];
              state_next = S_RD;
            end else begin
              // count drops now; loop runs while ptr is below the new count
              count_next = count - CW'(1);
              ptr_next   = cand[AW-1:0];
              state_next = (cand + POS_W'(1) < cnt_w) ? S_RD : S_DONE;
            end
          end
        end
      end

      S_RD: begin
        mem_req.re = 1'b1;
        if (op == OP_INSERT) begin
          mem_req.raddr = ptr - AW'(1);
          state_next    = S_WR;
        end else if (op == OP_REMOVE) begin
          mem_req.raddr = ptr + AW'(1);
          state_next    = S_WR;
        end else begin
          mem_req.raddr = ptr;
          state_next    = S_DONE;
        end
      end

      S_WR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = ptr;
        mem_req.wdata = mem_rdata;
        if (op == OP_INSERT) begin
          ptr_next   = ptr - AW'(1);
          state_next = (ptr_w - POS_W'(1) > pos_w) ? S_RD : S_PUT;
        end else begin
          ptr_next   = ptr + AW'(1);
          state_next = (ptr_w + POS_W'(1) < cnt_w) ? S_RD : S_DONE;
        end
      end

      S_PUT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        mem_req.wdata = word;
        count_next    = count + CW'(1);
        state_next    = S_DONE;
      end

      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    res.status      = status;
    res.read_value  = (op == OP_READ && status == ST_OK) ? 32'(mem_rdata) : 32'd0;
    res.entry_total = CAP_W'(count);
    res.is_empty    = (count == '0);
    res.is_full     = (count >= cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    pos    <= pos_next;
    op     <= op_next;
    status <= status_next;
    word   <= word_next;
  end

endmodule

// ===== rtl/indexed_insert_remove_array.sv =====
// Indexed insert/remove list. An accepted read passes S_RD; an insert runs one S_RD/S_WR
// pair per moved entry, then S_PUT; a remove, one pair per moved entry; a failed or no-op
// request goes straight to S_DONE. One item at a time; the shift loop, one slot read then
// one slot write per moved entry, sets the pace. A held result stalls s_tready.
// Reset (synchronous, rst high): list empty, capacity_limit 64, output empty.
// Slot contents are not cleared; only slots below the count are ever read.
module indexed_insert_remove_array
  import ilist_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [7:0] index, [39:8] element_value
  input  logic [3:0]  s_tuser,   // [1:0] operation, [3:2] position_mode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [31:0] read_value, [38:32] entry_total,
                                 // [39] is_empty, [40] is_full, [47:41] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [CAP_W-1:0]      capacity_limit;
  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] mem_rdata;
  logic                  res_valid;
  logic                  res_take;
  result_t               res;
  result_t               out_q;

  // register port: always ready, write on the access cycle
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_CAPACITY) ? 32'(capacity_limit) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= CAP_W'(64);
    end else if (psel && penable && pwrite && pready && paddr == ADDR_CAPACITY) begin
      capacity_limit <= pwdata[CAP_W-1:0];
    end
  end

  ilist_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  ilist_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .capacity_limit (capacity_limit),
    .req_valid      (s_tvalid),
    .req_ready      (s_tready),
    .operation      (s_tuser[1:0]),
    .position_mode  (s_tuser[3:2]),
    .index          (s_tdata[7:0]),
    .element_value  (s_tdata[39:8]),
    .mem_req        (mem_req),
    .mem_rdata      (mem_rdata),
    .res_valid      (res_valid),
    .res_take       (res_take),
    .res            (res)
  );

  // output register: loads when empty or being drained
  assign res_take = res_valid && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_tuser = out_q.status;
  assign m_tdata = {7'd0, out_q.is_full, out_q.is_empty, out_q.entry_total,
                    out_q.read_value};

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for indexed_insert_remove_array: directed and random list requests,
// capacity_limit writes over the register port, and predicted results for every item.
// Depends on rtl/ilist_pkg.sv and rtl/indexed_insert_remove_array.sv.
module tb;
  import ilist_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SEGMENTS     = 8;
  localparam int SEG_ITEMS    = 130;
  localparam int HOLDOFF_LEN  = 400;
  localparam int SETTLE       = 8;
  localparam int TAIL_CYCLES  = 150;   // longer than the slowest insert shift

  // Tracks the list contents and capacity, and keeps the results still to arrive.
  class list_tracker;
    logic [DATA_WIDTH-1:0] slot_words [DEPTH];
    int unsigned entry_count;
    int unsigned capacity_reg;
    int unsigned mismatches;
    result_t expected_results [$];

    function new();
      entry_count  = 0;
      capacity_reg = 64;
      mismatches   = 0;
    endfunction

    function void write_capacity(logic [CAP_W-1:0] value);
      capacity_reg = 32'(value);
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    function void report(string what, logic [31:0] want, logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $realtime, what, want, got);
    endfunction

    // Applies one accepted request to the tracked list and queues its result.
    function void note_request(logic [1:0] op, logic [1:0] mode, logic [7:0] idx,
                               logic [31:0] word);
      int unsigned limit;
      int unsigned pos;
      logic [1:0]  status;
      logic [31:0] rd;
      result_t     res;
      limit  = (capacity_reg > DEPTH) ? DEPTH : capacity_reg;
      pos    = 0;
      status = ST_OK;
      rd     = '0;
      if (op == OP_INSERT) begin
        if (entry_count >= limit) begin
          status = ST_FULL;
        end else begin
          case (mode)
            MODE_INDEX: pos = 32'(idx);
            MODE_FIRST: pos = 0;
            MODE_LAST:  pos = entry_count;
            default:    status = ST_BADIDX;
          endcase
          if (status == ST_OK && pos > entry_count) status = ST_BADIDX;
          if (status == ST_OK) begin
            for (int i = entry_count; i > pos; i--) slot_words[i] = slot_words[i-1];
            slot_words[pos] = word;
            entry_count++;
          end
        end
      end else if (op == OP_READ || op == OP_REMOVE) begin
        if (entry_count == 0) begin
          status = ST_EMPTY;
        end else begin
          case (mode)
            MODE_INDEX: pos = 32'(idx);
            MODE_FIRST: pos = 0;
            MODE_LAST:  pos = entry_count - 1;
            default:    status = ST_BADIDX;
          endcase
          if (status == ST_OK && pos >= entry_count) status = ST_BADIDX;
          if (status == ST_OK) begin
            if (op == OP_READ) begin
              rd = slot_words[pos];
            end else begin
              for (int i = pos; i + 1 < entry_count; i++) slot_words[i] = slot_words[i+1];
              entry_count--;
            end
          end
        end
      end
      res.status      = status;
      res.read_value  = rd;
      res.entry_total = entry_count[CAP_W-1:0];
      res.is_empty    = (entry_count == 0);
      res.is_full     = (entry_count >= limit);
      expected_results.push_back(res);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        report("unexpected result, status", 32'd0, 32'(got.status));
        return;
      end
      want = expected_results.pop_front();
      if (got.status != want.status)           report("status", 32'(want.status),
                                                      32'(got.status));
      if (got.read_value != want.read_value)   report("read_value", want.read_value,
                                                      got.read_value);
      if (got.entry_total != want.entry_total) report("entry_total", 32'(want.entry_total),
                                                      32'(got.entry_total));
      if (got.is_empty != want.is_empty)       report("is_empty", 32'(want.is_empty),
                                                      32'(got.is_empty));
      if (got.is_full != want.is_full)         report("is_full", 32'(want.is_full),
                                                      32'(got.is_full));
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // [7:0] index, [39:8] element_value
  logic [3:0]  s_tuser;   // [1:0] operation, [3:2] position_mode
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;   // [31:0] read_value, [38:32] entry_total, [39] is_empty,
                          // [40] is_full, [47:41] zero
  logic [1:0]  m_tuser;   // [1:0] status
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  list_tracker tracker = new();

  int send_idle_pct;      // chance per cycle that the sender holds back
  int recv_stall_pct;     // chance per cycle that the receiver stalls
  int holdoff_requests;   // bumped by the stimulus, served by the receiver
  int cycle_count;

  indexed_insert_remove_array i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: ends the run if the stimulus or the results hang.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("indexed_insert_remove_array regression: fail");
    $finish;
  end

  // Receiver: random stalls per phase; a long hold-off when one is requested, so the
  // block keeps a finished item and has to back-pressure the request side.
  initial begin : result_sink
    int served;
    int holdoff_left;
    served       = 0;
    holdoff_left = 0;
    m_tready     = 1'b0;
    forever begin
      @(negedge clk);
      if (served != holdoff_requests) begin
        served       = holdoff_requests;
        holdoff_left = HOLDOFF_LEN;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Every accepted result is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      tracker.check_result(result_t'{m_tuser, m_tdata[31:0], m_tdata[38:32],
                                     m_tdata[39], m_tdata[40]});
  end

  task automatic set_idling(input int phase);
    case (phase)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
      default: begin send_idle_pct = 21; recv_stall_pct = 21; end
    endcase
  endtask

  // Offers one request; returns at the falling edge after it was taken, with
  // tvalid still high so back-to-back items need no extra cycle.
  task automatic send_request(input logic [1:0] op, input logic [1:0] mode,
                              input logic [7:0] idx, input logic [31:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = {mode, op};
    s_tdata  = {word, idx};
    do @(posedge clk); while (!s_tready);
    tracker.note_request(op, mode, idx, word);
    @(negedge clk);
  endtask

  // Stops offering and waits for every predicted result, then a few quiet cycles.
  task automatic drain(input int quiet);
    s_tvalid = 1'b0;
    while (tracker.outstanding() != 0) @(negedge clk);
    repeat (quiet) @(negedge clk);
  endtask

  // Register write (setup, access), then a read back of the same register.
  task automatic write_capacity_reg(input logic [31:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = ADDR_CAPACITY;
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    tracker.write_capacity(value[CAP_W-1:0]);
    @(negedge clk);
    pwrite  = 1'b0;
    penable = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata != {25'd0, value[CAP_W-1:0]})
      tracker.report("capacity_limit read back", {25'd0, value[CAP_W-1:0]}, prdata);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Mostly well-formed requests against the current list; a tail of
  // out-of-range indexes, the unused mode and the unused operation.
  task automatic random_request(input int ins_pct, input int rem_pct);
    logic [1:0]  op;
    logic [1:0]  mode;
    logic [7:0]  idx;
    logic [31:0] word;
    int          roll;
    int unsigned n;
    n    = tracker.entry_count;
    roll = $urandom_range(99);
    if (roll < ins_pct)                op = OP_INSERT;
    else if (roll < ins_pct + rem_pct) op = OP_REMOVE;
    else                               op = OP_READ;
    word = $urandom;
    idx  = 8'($urandom);
    roll = $urandom_range(99);
    if (roll < 55) begin
      mode = MODE_INDEX;
      if (op == OP_INSERT) idx = 8'($urandom_range(n, 0));
      else if (n > 0)      idx = 8'($urandom_range(n - 1, 0));
    end else if (roll < 72) begin
      mode = MODE_FIRST;
    end else if (roll < 89) begin
      mode = MODE_LAST;
    end else if (roll < 94) begin
      mode = MODE_INDEX;                  // whole index range, mostly out of bounds
    end else if (roll < 97) begin
      mode = MODE_NONE;
    end else begin
      op   = OP_NONE;
      mode = 2'($urandom);
    end
    send_request(op, mode, idx, word);
  endtask

  initial begin : stimulus
    int seg_caps [SEGMENTS];
    int seg_ins  [SEGMENTS];
    int seg_rem  [SEGMENTS];
    int cap;
    seg_caps         = '{64, 3, 0, 127, 1, 0, 65, 64};
    seg_ins          = '{75, 30, 40, 60, 45, 55, 50, 30};
    seg_rem          = '{10, 45, 35, 25, 35, 30, 30, 55};
    rst              = 1'b1;
    s_tvalid         = 1'b0;
    s_tdata          = '0;
    s_tuser          = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    holdoff_requests = 0;
    set_idling(0);
    repeat (7) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed: empty list, bad positions, all modes, data extremes, unused codes.
    send_request(OP_READ,   MODE_FIRST, 8'd0,   32'h0);          // empty
    send_request(OP_REMOVE, MODE_LAST,  8'd0,   32'h0);          // empty
    send_request(OP_INSERT, MODE_INDEX, 8'd1,   32'h1);          // index past count
    send_request(OP_INSERT, MODE_NONE,  8'd0,   32'h2);          // unused mode
    send_request(OP_INSERT, MODE_INDEX, 8'd0,   32'h0000_0000);
    send_request(OP_INSERT, MODE_LAST,  8'd0,   32'hFFFF_FFFF);
    send_request(OP_INSERT, MODE_FIRST, 8'd0,   32'hA5A5_A5A5);
    send_request(OP_INSERT, MODE_INDEX, 8'd3,   32'h5A5A_5A5A);  // index == count appends
    send_request(OP_INSERT, MODE_INDEX, 8'd1,   32'h1234_5678);
    send_request(OP_READ,   MODE_INDEX, 8'd255, 32'h0);          // top index
    send_request(OP_READ,   MODE_INDEX, 8'd5,   32'h0);          // index == count
    send_request(OP_READ,   MODE_NONE,  8'd0,   32'h0);
    send_request(OP_READ,   MODE_FIRST, 8'd0,   32'h0);
    send_request(OP_READ,   MODE_LAST,  8'd0,   32'h0);
    send_request(OP_READ,   MODE_INDEX, 8'd2,   32'h0);
    send_request(OP_NONE,   MODE_INDEX, 8'hFF,  32'hFFFF_FFFF);  // unused operation
    send_request(OP_REMOVE, MODE_INDEX, 8'd1,   32'h0);
    send_request(OP_REMOVE, MODE_FIRST, 8'd0,   32'h0);
    send_request(OP_REMOVE, MODE_LAST,  8'd0,   32'h0);
    send_request(OP_REMOVE, MODE_INDEX, 8'd2,   32'h0);          // index == count
    send_request(OP_REMOVE, MODE_NONE,  8'd0,   32'h0);
    send_request(OP_REMOVE, MODE_INDEX, 8'd0,   32'h0);
    send_request(OP_REMOVE, MODE_INDEX, 8'd0,   32'h0);          // list empty again
    send_request(OP_READ,   MODE_INDEX, 8'd0,   32'h0);          // empty

    // Random segments. Each starts idle with a new capacity: fill to the top,
    // drop below the count, zero, above the depth, one, a random one.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain(SETTLE);
      cap = (seg == 5) ? $urandom_range(64, 1) : seg_caps[seg];
      write_capacity_reg(cap);
      set_idling(seg % 4);
      for (int k = 0; k < SEG_ITEMS; k++) begin
        // long receiver hold-off while requests keep coming
        if (seg == 0 && k == 20) holdoff_requests++;
        // sender waits for every outstanding result mid-stream
        if (seg == 4 && k == 65) drain(0);
        random_request(seg_ins[seg], seg_rem[seg]);
      end
    end

    drain(TAIL_CYCLES);
    if (tracker.outstanding() == 0 && tracker.mismatches == 0) begin
      $display("indexed_insert_remove_array regression: pass");
    end else begin
      $display("indexed_insert_remove_array regression: fail");
    end
    $finish;
  end

endmodule
